/* rtl/tpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpd_pkg
// Types, codes and helpers shared by the typed packet deframer.
// ----------------------------------------------------------------------------
package tpd_pkg;

	localparam int ByteW = 8;
	localparam int KindW = 3;
	localparam int LenW  = 16;
	localparam int SumW  = 16;

	// Header parse phase
	typedef enum logic [2:0] {
		PH_TYPE    = 3'd0,
		PH_LEN_HI  = 3'd1,
		PH_LEN_LO  = 3'd2,
		PH_SUM_HI  = 3'd3,
		PH_SUM_LO  = 3'd4,
		PH_TERM    = 3'd5,
		PH_PAYLOAD = 3'd6
	} phase_t;

	// Known type bytes
	localparam logic [ByteW-1:0] TYPE_DISCONNECT = 8'h00;
	localparam logic [ByteW-1:0] TYPE_CONNECT    = 8'h01;
	localparam logic [ByteW-1:0] TYPE_GAMESTATE  = 8'h10;
	localparam logic [ByteW-1:0] TYPE_ALREADY    = 8'hFB;
	localparam logic [ByteW-1:0] TYPE_BADPLAYER  = 8'hFC;
	localparam logic [ByteW-1:0] TYPE_BADSUM     = 8'hFD;
	localparam logic [ByteW-1:0] TYPE_BADHEADER  = 8'hFE;
	localparam logic [ByteW-1:0] TYPE_ERROR      = 8'hFF;

	// Dense kind codes
	localparam logic [KindW-1:0] KIND_DISCONNECT = 3'd0;
	localparam logic [KindW-1:0] KIND_CONNECT    = 3'd1;
	localparam logic [KindW-1:0] KIND_GAMESTATE  = 3'd2;
	localparam logic [KindW-1:0] KIND_ALREADY    = 3'd3;
	localparam logic [KindW-1:0] KIND_BADPLAYER  = 3'd4;
	localparam logic [KindW-1:0] KIND_BADSUM     = 3'd5;
	localparam logic [KindW-1:0] KIND_BADHEADER  = 3'd6;
	localparam logic [KindW-1:0] KIND_ERROR      = 3'd7;

	typedef struct packed {
		logic             known;
		logic [KindW-1:0] kind;
	} kind_map_t;

	// One result word
	typedef struct packed {
		logic [ByteW-1:0] payload_byte;
		logic             has_byte;
		logic [KindW-1:0] msg_kind;
		logic             is_last;
		logic             checksum_ok;
		logic             header_error;
	} res_t;

	function automatic kind_map_t map_kind(input logic [ByteW-1:0] b);
		kind_map_t m;
		m.known = 1'b1;
		m.kind  = KIND_DISCONNECT;
		unique case (b)
			TYPE_DISCONNECT: m.kind = KIND_DISCONNECT;
			TYPE_CONNECT:    m.kind = KIND_CONNECT;
			TYPE_GAMESTATE:  m.kind = KIND_GAMESTATE;
			TYPE_ALREADY:    m.kind = KIND_ALREADY;
			TYPE_BADPLAYER:  m.kind = KIND_BADPLAYER;
			TYPE_BADSUM:     m.kind = KIND_BADSUM;
			TYPE_BADHEADER:  m.kind = KIND_BADHEADER;
			TYPE_ERROR:      m.kind = KIND_ERROR;
			default:         m.known = 1'b0;
		endcase
		return m;
	endfunction

endpackage

/* rtl/tpd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpd_if
// Valid/ready channels of the deframer: raw byte in, result word out.
// ----------------------------------------------------------------------------
interface tpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface tpd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       has_byte;
	logic [2:0] msg_kind;
	logic       is_last;
	logic       checksum_ok;
	logic       header_error;

	modport source (output valid, output payload_byte, output has_byte, output msg_kind,
		output is_last, output checksum_ok, output header_error, input ready);
	modport sink   (input valid, input payload_byte, input has_byte, input msg_kind,
		input is_last, input checksum_ok, input header_error, output ready);
endinterface

/* rtl/tpd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpd_parser
// Header/payload state and the per-byte result logic.
// ----------------------------------------------------------------------------
module tpd_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [tpd_pkg::ByteW-1:0] data_byte,
	input  logic                      fire,
	output logic                      produce,
	output tpd_pkg::res_t             res
);
	import tpd_pkg::*;

	phase_t               phase_q, phase_d;
	logic [KindW-1:0]     kind_q, kind_d;
	logic [LenW-1:0]      left_q, left_d;
	logic [SumW-1:0]      sum_q, sum_d;
	logic [ByteW-1:0]     xor_q, xor_d;
	kind_map_t            km;
	logic [LenW-1:0]      left_dec;
	logic [ByteW-1:0]     xor_nx;

	assign km       = map_kind(data_byte);
	assign left_dec = left_q - LenW'(1);
	assign xor_nx   = xor_q ^ data_byte;

	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		left_d  = left_q;
		sum_d   = sum_q;
		xor_d   = xor_q;
		produce = 1'b0;
		res     = '0;
		unique case (phase_q)
			PH_LEN_HI: begin
				left_d  = {data_byte, left_q[ByteW-1:0] & 8'h00};
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				left_d  = {left_q[LenW-1:ByteW], data_byte};
				phase_d = PH_SUM_HI;
			end
			PH_SUM_HI: begin
				sum_d   = {data_byte, {ByteW{1'b0}}};
				phase_d = PH_SUM_LO;
			end
			PH_SUM_LO: begin
				sum_d   = {sum_q[SumW-1:ByteW], data_byte};
				phase_d = PH_TERM;
			end
			PH_TERM: begin
				xor_d = '0;
				if (left_q == '0) begin
					phase_d         = PH_TYPE;
					produce         = 1'b1;
					res.msg_kind    = kind_q;
					res.is_last     = 1'b1;
					res.checksum_ok = (sum_q == '0);
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				xor_d            = xor_nx;
				left_d           = left_dec;
				produce          = 1'b1;
				res.payload_byte = data_byte;
				res.has_byte     = 1'b1;
				res.msg_kind     = kind_q;
				if (left_dec == '0) begin
					res.is_last     = 1'b1;
					res.checksum_ok = ({{(SumW-ByteW){1'b0}}, xor_nx} == sum_q);
					phase_d         = PH_TYPE;
				end
			end
			default: begin
				// type phase; the unused code lands here too
				if (km.known) begin
					kind_d  = km.kind;
					xor_d   = '0;
					phase_d = PH_LEN_HI;
				end else begin
					phase_d          = PH_TYPE;
					produce          = 1'b1;
					res.is_last      = 1'b1;
					res.header_error = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			kind_q  <= '0;
			left_q  <= '0;
			sum_q   <= '0;
			xor_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			left_q  <= left_d;
			sum_q   <= sum_d;
			xor_q   <= xor_d;
		end
	end

endmodule

/* rtl/typed_packet_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_packet_deframer
// Splits a byte stream into typed packets and passes the payload on.
// ----------------------------------------------------------------------------
// Takes one raw byte per cycle on "stream" and gives at most one result word
// per byte on "result". A packet is a six-byte header (type, 16-bit big-endian
// length, 16-bit big-endian checksum, terminator) and then the payload. Header
// bytes give no word; each payload byte gives one word carrying the byte and
// the packet's kind code, and the last one has is_last set and checksum_ok
// telling whether the payload XOR matched the checksum. An empty packet gives
// a single last word on its terminator. An unknown type byte gives one word
// with header_error set, and the next byte is taken as a new type byte.
// Throughput is one byte per cycle while the sink keeps up; an accepted byte
// passes the input register, then the result register, before its word shows.
// The input register is freed only when its byte's result can be written to
// the result register, so a stalled sink holds back bytes that make a word;
// header bytes drain regardless.
// ----------------------------------------------------------------------------
module typed_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	tpd_byte_if.sink    stream,
	tpd_res_if.source   result
);
	import tpd_pkg::*;

	// input register
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;

	// result register
	logic             valid_s2;
	res_t             res_s2;

	logic             produce;
	logic             space;
	logic             advance;
	res_t             res_c;

	tpd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_byte(byte_s1),
		.fire     (advance),
		.produce  (produce),
		.res      (res_c)
	);

	// result register free, or emptied this cycle
	assign space        = !valid_s2 || result.ready;
	assign advance      = valid_s1 && (!produce || space);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (space) begin
			valid_s2 <= advance && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (space && advance && produce) begin
			res_s2 <= res_c;
		end
	end

	assign result.valid        = valid_s2;
	assign result.payload_byte = res_s2.payload_byte;
	assign result.has_byte     = res_s2.has_byte;
	assign result.msg_kind     = res_s2.msg_kind;
	assign result.is_last      = res_s2.is_last;
	assign result.checksum_ok  = res_s2.checksum_ok;
	assign result.header_error = res_s2.header_error;

endmodule
